/* design/bpa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, codes, types and helper functions of the buddy allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int POOL_PAGES = 1024;
	localparam int LOG_POOL   = 10;
	localparam int NODES      = 2 * POOL_PAGES - 1;
	localparam int IDX_W      = LOG_POOL + 1;
	localparam int VAL_W      = LOG_POOL + 1;
	localparam int REQ_W      = 11;
	localparam int WANT_W     = REQ_W + 1;
	localparam int OFF_W      = 10;
	localparam int CFG_W      = 11;

	localparam logic [1:0] OP_REBUILD = 2'd0;
	localparam logic [1:0] OP_ALLOC   = 2'd1;
	localparam logic [1:0] OP_FREE    = 2'd2;

	localparam logic [1:0] K_REBUILD = 2'd0;
	localparam logic [1:0] K_ALLOC   = 2'd1;
	localparam logic [1:0] K_FREE    = 2'd2;
	localparam logic [1:0] K_NOP     = 2'd3;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NOSPACE  = 2'd1;
	localparam logic [1:0] STAT_NOTALLOC = 2'd2;

	typedef struct packed {
		logic [1:0]        kind;
		logic [WANT_W-1:0] want;
		logic [OFF_W-1:0]  off;
	} cmd_t;

	function automatic logic [WANT_W-1:0] round_pow2(input logic [REQ_W-1:0] req);
		logic [REQ_W-1:0]  x;
		logic [WANT_W-1:0] r;
		x = req - REQ_W'(1);
		r = WANT_W'(1);
		if (req > REQ_W'(1)) begin
			for (int i = 0; i < REQ_W; i++) begin
				if (x[i])
					r = WANT_W'(1) << (i + 1);
			end
		end
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] high_bit(input logic [VAL_W-1:0] v);
		logic [VAL_W-1:0] r;
		r = '0;
		for (int i = 0; i < VAL_W; i++) begin
			if (v[i])
				r = VAL_W'(1) << i;
		end
		return r;
	endfunction

endpackage

/* design/buddy_page_allocator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_page_allocator_top
// Binary buddy page allocator over a longest-free-run tree of pool pages.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries operation, request_pages and
// free_offset; a transfer takes place when in_valid is high and in_stall low.
// Output channel (out_valid / out_stall) returns status and alloc_offset,
// one transfer per input item, in order.
// cfg_valid / cfg_ready writes forbidden_pages; used by the next rebuild.
// Items go through a two-entry queue to the sequencer, one at a time.
// Allocate: a root test, a descent to the level of the rounded request,
// a mark, then a climb back to the root. Free: a climb from the leaf to
// the marked node, a mark, then a climb back to the root.
// Rebuild: one tree node written per cycle.
// The tree memory port (two reads, one write per cycle) paces these steps.
// After reset the tree is rebuilt with no forbidden pages; in_stall stays
// high during that rebuild. When the receiver stalls the result holds in
// the output register; the queue keeps accepting until it fills.
// ----------------------------------------------------------------------------
module buddy_page_allocator_top import bpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        operation,
	input  logic [REQ_W-1:0]  request_pages,
	input  logic [OFF_W-1:0]  free_offset,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [OFF_W-1:0]  alloc_offset,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  forbidden_pages
);

	logic [CFG_W-1:0] forbidden_q;
	logic             q_push, q_full, q_pop, q_empty, init_busy;
	cmd_t             push_cmd, pop_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			forbidden_q <= '0;
		else if (cfg_valid)
			forbidden_q <= forbidden_pages;
	end

	bpa_front u_front (
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.request_pages (request_pages),
		.free_offset   (free_offset),
		.q_full        (q_full),
		.init_busy     (init_busy),
		.q_push        (q_push),
		.q_cmd         (push_cmd)
	);

	bpa_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.pop_cmd  (pop_cmd)
	);

	bpa_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_cmd        (pop_cmd),
		.q_pop        (q_pop),
		.forbidden    (forbidden_q),
		.init_busy    (init_busy),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.alloc_offset (alloc_offset)
	);

endmodule

/* design/bpa_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_front
// Accepts input items, classifies the operation and rounds the request.
// ----------------------------------------------------------------------------
module bpa_front import bpa_pkg::*; (
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        operation,
	input  logic [REQ_W-1:0]  request_pages,
	input  logic [OFF_W-1:0]  free_offset,
	input  logic              q_full,
	input  logic              init_busy,
	output logic              q_push,
	output cmd_t              q_cmd
);

	assign in_stall = q_full | init_busy;
	assign q_push   = in_valid & ~in_stall;

	always_comb begin
		q_cmd.want = round_pow2(request_pages);
		q_cmd.off  = free_offset;
		case (operation)
			OP_REBUILD: q_cmd.kind = K_REBUILD;
			OP_ALLOC:   q_cmd.kind = K_ALLOC;
			OP_FREE:    q_cmd.kind = K_FREE;
			default:    q_cmd.kind = K_NOP;
		endcase
	end

endmodule

/* design/bpa_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_fifo
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module bpa_fifo import bpa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t pop_cmd
);

	cmd_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign pop_cmd = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wp_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

/* design/bpa_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_back
// Tree memory and sequencer: rebuild sweep, descent, climb and result slot.
// ----------------------------------------------------------------------------
module bpa_back import bpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  cmd_t              q_cmd,
	output logic              q_pop,
	input  logic [CFG_W-1:0]  forbidden,
	output logic              init_busy,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [OFF_W-1:0]  alloc_offset
);

	localparam logic [3:0] S_SWEEP   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_AL_TEST = 4'd2;
	localparam logic [3:0] S_AL_DOWN = 4'd3;
	localparam logic [3:0] S_MARK    = 4'd4;
	localparam logic [3:0] S_FR_TEST = 4'd5;
	localparam logic [3:0] S_UP      = 4'd6;
	localparam logic [3:0] S_RESULT  = 4'd7;

	localparam logic [VAL_W-1:0] POOL_V    = VAL_W'(POOL_PAGES);
	localparam logic [IDX_W-1:0] LEAF_BASE = IDX_W'(POOL_PAGES - 1);
	localparam logic [IDX_W-1:0] LAST_NODE = IDX_W'(NODES - 1);

	logic [VAL_W-1:0] tree_mem [NODES];
	logic [VAL_W-1:0] rd0, rd1;
	logic [IDX_W-1:0] ra0, ra1, wa;
	logic [VAL_W-1:0] wd;
	logic             we;

	logic [3:0]        state_q;
	logic [IDX_W-1:0]  idx_q;
	logic [VAL_W-1:0]  span_q;
	logic [VAL_W-1:0]  val_q;
	logic [WANT_W-1:0] want_q;
	logic [OFF_W-1:0]  off_q;
	logic              free_q;
	logic [VAL_W-1:0]  a_q;
	logic [VAL_W-1:0]  bnd_q;
	logic              reb_res_q;
	logic [1:0]        res_stat_q;
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [OFF_W-1:0]  alloc_offset_q;

	logic [VAL_W:0]    a_end;
	logic [VAL_W-1:0]  sweep_val;
	logic [IDX_W-1:0]  parent, sibling, pparent_sib, child;
	logic              go_right;
	logic [VAL_W-1:0]  up_val;
	logic [VAL_W-1:0]  span_up;
	logic              slot_free;
	logic              res_fire;
	logic [CFG_W-1:0]  f_clip;

	always_ff @(posedge clk) begin
		if (we)
			tree_mem[wa] <= wd;
		rd0 <= tree_mem[ra0];
		rd1 <= tree_mem[ra1];
	end

	assign a_end     = {1'b0, a_q} + {1'b0, span_q};
	assign parent    = (idx_q - IDX_W'(1)) >> 1;
	assign sibling   = idx_q[0] ? idx_q + IDX_W'(1) : idx_q - IDX_W'(1);
	assign pparent_sib = parent[0] ? parent + IDX_W'(1) : parent - IDX_W'(1);
	assign span_up   = span_q << 1;
	assign slot_free = ~out_valid_q | ~out_stall;
	assign res_fire  = (state_q == S_RESULT) & slot_free;
	assign f_clip    = (forbidden >= CFG_W'(POOL_PAGES)) ? CFG_W'(POOL_PAGES) : forbidden;

	always_comb begin
		if (a_end <= {1'b0, bnd_q})
			sweep_val = span_q;
		else if (a_q >= bnd_q)
			sweep_val = '0;
		else
			sweep_val = high_bit(bnd_q - a_q);
	end

	always_comb begin
		if (rd0 > rd1)
			go_right = {1'b0, rd1} >= want_q;
		else
			go_right = ~({1'b0, rd0} >= want_q);
		child = go_right ? {idx_q[IDX_W-2:0], 1'b0} + IDX_W'(2)
		                 : {idx_q[IDX_W-2:0], 1'b1};
	end

	always_comb begin
		if (free_q && val_q == span_q && rd0 == span_q)
			up_val = span_up;
		else
			up_val = (val_q > rd0) ? val_q : rd0;
	end

	assign init_busy = (state_q == S_SWEEP) & ~reb_res_q;
	assign q_pop     = (state_q == S_IDLE) & ~q_empty;

	always_comb begin
		ra0 = '0;
		ra1 = '0;
		we  = 1'b0;
		wa  = idx_q;
		wd  = '0;
		case (state_q)
			S_SWEEP: begin
				we = 1'b1;
				wd = sweep_val;
			end
			S_IDLE: begin
				ra0 = (q_cmd.kind == K_FREE) ? {1'b0, q_cmd.off} + LEAF_BASE : '0;
			end
			S_AL_TEST: begin
				ra0 = {idx_q[IDX_W-2:0], 1'b1};
				ra1 = {idx_q[IDX_W-2:0], 1'b0} + IDX_W'(2);
			end
			S_AL_DOWN: begin
				ra0 = {child[IDX_W-2:0], 1'b1};
				ra1 = {child[IDX_W-2:0], 1'b0} + IDX_W'(2);
			end
			S_MARK: begin
				we  = 1'b1;
				ra0 = sibling;
			end
			S_FR_TEST: begin
				if (rd0 == '0) begin
					we  = 1'b1;
					wd  = span_q;
					ra0 = sibling;
				end else begin
					ra0 = parent;
				end
			end
			S_UP: begin
				we  = 1'b1;
				wa  = parent;
				wd  = up_val;
				ra0 = pparent_sib;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_SWEEP;
			idx_q          <= '0;
			span_q         <= POOL_V;
			val_q          <= '0;
			want_q         <= '0;
			off_q          <= '0;
			free_q         <= 1'b0;
			a_q            <= '0;
			bnd_q          <= POOL_V;
			reb_res_q      <= 1'b0;
			res_stat_q     <= STAT_OK;
			out_valid_q    <= 1'b0;
			status_q       <= STAT_OK;
			alloc_offset_q <= '0;
		end else begin
			if (res_fire)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_SWEEP: begin
					idx_q <= idx_q + IDX_W'(1);
					if (a_end == {1'b0, POOL_V}) begin
						a_q    <= '0;
						span_q <= span_q >> 1;
					end else begin
						a_q <= a_end[VAL_W-1:0];
					end
					if (idx_q == LAST_NODE) begin
						res_stat_q <= STAT_OK;
						off_q      <= '0;
						state_q    <= reb_res_q ? S_RESULT : S_IDLE;
					end
				end
				S_IDLE: begin
					if (!q_empty) begin
						want_q <= q_cmd.want;
						off_q  <= '0;
						case (q_cmd.kind)
							K_REBUILD: begin
								idx_q     <= '0;
								a_q       <= '0;
								span_q    <= POOL_V;
								bnd_q     <= POOL_V - f_clip[VAL_W-1:0];
								reb_res_q <= 1'b1;
								state_q   <= S_SWEEP;
							end
							K_ALLOC: begin
								idx_q   <= '0;
								span_q  <= POOL_V;
								free_q  <= 1'b0;
								state_q <= S_AL_TEST;
							end
							K_FREE: begin
								idx_q   <= {1'b0, q_cmd.off} + LEAF_BASE;
								span_q  <= VAL_W'(1);
								free_q  <= 1'b1;
								state_q <= S_FR_TEST;
							end
							default: begin
								res_stat_q <= STAT_OK;
								state_q    <= S_RESULT;
							end
						endcase
					end
				end
				S_AL_TEST: begin
					if ({1'b0, rd0} < want_q) begin
						res_stat_q <= STAT_NOSPACE;
						state_q    <= S_RESULT;
					end else if ({1'b0, span_q} == want_q) begin
						state_q <= S_MARK;
					end else begin
						state_q <= S_AL_DOWN;
					end
				end
				S_AL_DOWN: begin
					idx_q  <= child;
					span_q <= span_q >> 1;
					if (go_right)
						off_q <= off_q + OFF_W'(span_q >> 1);
					if ({1'b0, span_q >> 1} == want_q)
						state_q <= S_MARK;
				end
				S_MARK: begin
					val_q <= '0;
					if (idx_q == '0) begin
						res_stat_q <= STAT_OK;
						state_q    <= S_RESULT;
					end else begin
						state_q <= S_UP;
					end
				end
				S_FR_TEST: begin
					if (rd0 == '0) begin
						val_q <= span_q;
						if (idx_q == '0) begin
							res_stat_q <= STAT_OK;
							state_q    <= S_RESULT;
						end else begin
							state_q <= S_UP;
						end
					end else if (idx_q == '0) begin
						res_stat_q <= STAT_NOTALLOC;
						state_q    <= S_RESULT;
					end else begin
						idx_q  <= parent;
						span_q <= span_up;
					end
				end
				S_UP: begin
					idx_q  <= parent;
					val_q  <= up_val;
					span_q <= span_up;
					if (parent == '0) begin
						res_stat_q <= STAT_OK;
						state_q    <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (slot_free) begin
						status_q       <= res_stat_q;
						alloc_offset_q <= (res_stat_q == STAT_OK && !free_q && !reb_res_q)
						                  ? off_q : '0;
						reb_res_q      <= 1'b0;
						free_q         <= 1'b0;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign alloc_offset = alloc_offset_q;

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the buddy page allocator against a behavioral longest-free-run tree.
// ----------------------------------------------------------------------------
// Directed rebuild/alloc/free corner cases, then long random alloc/free runs
// over several forbidden-page settings. Each accepted result is compared
// in order with the tree prediction. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
	import bpa_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        operation;
	logic [REQ_W-1:0]  request_pages;
	logic [OFF_W-1:0]  free_offset;
	logic              out_valid;
	logic              out_stall;
	logic [1:0]        status;
	logic [OFF_W-1:0]  alloc_offset;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CFG_W-1:0]  forbidden_pages;

	typedef struct packed {
		logic [1:0]       st;
		logic [OFF_W-1:0] off;
	} grant_t;

	int unsigned tree_val [NODES];
	int unsigned excluded;
	grant_t      pending_grants [$];
	int unsigned live_offsets [$];
	int          errors;
	bit          idle_free;
	int          hold_cycles;

	buddy_page_allocator_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .request_pages(request_pages),
		.free_offset(free_offset),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .alloc_offset(alloc_offset),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.forbidden_pages(forbidden_pages)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("tb failed");
		$finish;
	end

	function automatic int unsigned merged(int unsigned idx, int unsigned span);
		int unsigned l, r;
		l = tree_val[2 * idx + 1];
		r = tree_val[2 * idx + 2];
		if (l == span / 2 && r == span / 2)
			return span;
		return (l > r) ? l : r;
	endfunction

	function automatic void rebuild_tree();
		int unsigned f;
		int unsigned first;
		f = (excluded < POOL_PAGES) ? excluded : POOL_PAGES;
		for (int unsigned i = 0; i < POOL_PAGES; i++)
			tree_val[POOL_PAGES - 1 + i] = (i >= POOL_PAGES - f) ? 0 : 1;
		for (int unsigned s = 2; s <= POOL_PAGES; s *= 2) begin
			first = POOL_PAGES / s - 1;
			for (int unsigned i = 0; i < POOL_PAGES / s; i++)
				tree_val[first + i] = merged(first + i, s);
		end
	endfunction

	function automatic grant_t predict_grant(logic [1:0] op, int unsigned req,
			int unsigned off);
		grant_t g;
		int unsigned want, idx, span, l, r;
		g = '0;
		if (op == OP_REBUILD) begin
			rebuild_tree();
		end else if (op == OP_ALLOC) begin
			want = 1;
			while (want < req)
				want <<= 1;
			if (tree_val[0] < want) begin
				g.st = STAT_NOSPACE;
				return g;
			end
			idx = 0;
			for (span = POOL_PAGES; span > want; span /= 2) begin
				l = tree_val[2 * idx + 1];
				r = tree_val[2 * idx + 2];
				if (l > r)
					idx = (r >= want) ? 2 * idx + 2 : 2 * idx + 1;
				else
					idx = (l >= want) ? 2 * idx + 1 : 2 * idx + 2;
			end
			tree_val[idx] = 0;
			g.off = OFF_W'((idx + 1) * span - POOL_PAGES);
			live_offsets.push_back(g.off);
			while (idx > 0) begin
				idx = (idx - 1) / 2;
				l = tree_val[2 * idx + 1];
				r = tree_val[2 * idx + 2];
				tree_val[idx] = (l > r) ? l : r;
			end
		end else if (op == OP_FREE) begin
			idx = off + POOL_PAGES - 1;
			span = 1;
			while (tree_val[idx] != 0) begin
				if (idx == 0) begin
					g.st = STAT_NOTALLOC;
					return g;
				end
				idx = (idx - 1) / 2;
				span *= 2;
			end
			tree_val[idx] = span;
			while (idx > 0) begin
				idx = (idx - 1) / 2;
				span *= 2;
				tree_val[idx] = merged(idx, span);
			end
		end
		return g;
	endfunction

	// one input transfer
	task automatic send_item(logic [1:0] op, int unsigned req, int unsigned off);
		if (!idle_free) begin
			while ($urandom_range(99) < 11) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid      <= 1'b1;
		operation     <= op;
		request_pages <= REQ_W'(req);
		free_offset   <= OFF_W'(off);
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_grants.push_back(predict_grant(op, req, off));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_excluded(int unsigned v);
		drain();
		cfg_valid       <= 1'b1;
		forbidden_pages <= CFG_W'(v);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		excluded = v;
	endtask

	task automatic rebuild_with(int unsigned v);
		write_excluded(v);
		live_offsets.delete();
		send_item(OP_REBUILD, $urandom_range(2047), $urandom_range(1023));
		drain();
	endtask

	task automatic test_directed();
		send_item(OP_ALLOC, 0, 0);
		send_item(OP_ALLOC, 1, 1023);
		send_item(OP_ALLOC, 3, 0);
		send_item(OP_ALLOC, 1024, 0);
		send_item(OP_ALLOC, 2047, 0);
		send_item(OP_FREE, 5, 0);
		send_item(OP_FREE, 0, 0);
		send_item(OP_FREE, 0, 0);
		send_item(OP_FREE, 0, 1023);
		send_item(OP_UNUSED, 2047, 1023);
		send_item(OP_ALLOC, 1024, 0);
		send_item(OP_ALLOC, 1, 0);
		send_item(OP_FREE, 0, 512);
		send_item(OP_REBUILD, 0, 0);
		drain();
		rebuild_with(1024);
		send_item(OP_ALLOC, 1, 0);
		send_item(OP_FREE, 0, 1023);
		send_item(OP_ALLOC, 1, 0);
		rebuild_with(2047);
		send_item(OP_ALLOC, 0, 0);
		send_item(OP_FREE, 0, 0);
		drain();
	endtask

	task automatic random_item();
		int unsigned pick, req;
		pick = $urandom_range(99);
		if (pick < 50) begin
			req = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(40);
			send_item(OP_ALLOC, req, $urandom_range(1023));
		end else if (pick < 85 && live_offsets.size() != 0) begin
			pick = $urandom_range(live_offsets.size() - 1);
			send_item(OP_FREE, $urandom_range(2047), live_offsets[pick]);
			live_offsets.delete(pick);
		end else if (pick < 97) begin
			send_item(OP_FREE, $urandom_range(2047), $urandom_range(1023));
		end else begin
			send_item(OP_UNUSED, $urandom_range(2047), $urandom_range(1023));
		end
	endtask

	task automatic test_random(int unsigned setting, int n);
		rebuild_with(setting);
		for (int i = 0; i < n; i++)
			random_item();
	endtask

	task automatic test_back_pressure();
		hold_cycles = 300;
		for (int i = 0; i < 20; i++)
			random_item();
		drain();
	endtask

	// output stall generator, with a quiet stretch and a long hold-off
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall   <= 1'b1;
		end else begin
			out_stall <= !idle_free && ($urandom_range(99) < 11);
		end
	end

	// result checker
	always @(posedge clk) begin
		grant_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_grants.size() == 0) begin
				$error("unexpected result status=%0d alloc_offset=%0d",
					status, alloc_offset);
				errors++;
			end else begin
				e = pending_grants.pop_front();
				if (status !== e.st) begin
					$error("status expected %0d actual %0d", e.st, status);
					errors++;
				end
				if (alloc_offset !== e.off) begin
					$error("alloc_offset expected %0d actual %0d", e.off, alloc_offset);
					errors++;
				end
			end
		end
	end

	initial begin
		errors          = 0;
		idle_free       = 1'b0;
		hold_cycles     = 0;
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		operation       = OP_REBUILD;
		request_pages   = '0;
		free_offset     = '0;
		out_stall       = 1'b0;
		cfg_valid       = 1'b0;
		forbidden_pages = '0;
		excluded        = 0;
		rebuild_tree();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(0, 260);
		test_back_pressure();
		test_random(100, 150);
		idle_free = 1'b1;
		test_random(3, 150);
		idle_free = 1'b0;
		test_random(1023, 60);
		test_random(512, 150);
		drain();
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
